FILE: design/mfpp_pkg.sv
// ----------------------------------------------------------------------------
// mfpp_pkg: shared definitions for the marker framed packet parser
// Parameter capacity, configuration register indexes and reset values, and
// the frame result type.
// ----------------------------------------------------------------------------
package mfpp_pkg;

  localparam int MAX_PARAMS = 12;
  localparam int ParamBits  = 8 * MAX_PARAMS;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START  = 2'd0;
  localparam cfg_idx_t CFG_SECOND = 2'd1;
  localparam cfg_idx_t CFG_FOOTER = 2'd2;

  localparam logic [7:0] START_RESET  = 8'd170;
  localparam logic [7:0] SECOND_RESET = 8'd85;
  localparam logic [7:0] FOOTER_RESET = 8'd126;

  typedef struct packed {
    logic [7:0]  source_id;
    logic [7:0]  command;
    logic [7:0]  operation;
    logic [7:0]  data_length;
    logic [63:0] params_low;
    logic [31:0] params_high;
    logic [7:0]  checksum;
    logic        oversize;
  } frame_t;

endpackage

FILE: design/marker_framed_packet_parser.sv
// ----------------------------------------------------------------------------
// marker_framed_packet_parser: byte stream frame parser
// One received byte is taken per cycle while rx_stall is low. The footer byte
// of a complete frame registers its frame result for the frame channel, in the
// output register, or in the skid register while the sink stalls.
// Throughput: 1 word per cycle unless stalled; rx_stall rises only when both
// the output and the skid register hold frames that the sink has not taken.
// Reset (rst, synchronous): parser idle, stored bytes cleared, markers back
// to 170, 85 and 126, no frame pending.
// ----------------------------------------------------------------------------
module marker_framed_packet_parser (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  mfpp_pkg::cfg_idx_t   cfg_index,
  input  logic [7:0]           cfg_data,
  // received bytes
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  // frame results
  output logic                 frame_valid,
  input  logic                 frame_stall,
  output logic [7:0]           source_id,
  output logic [7:0]           command,
  output logic [7:0]           operation,
  output logic [7:0]           data_length,
  output logic [63:0]          params_low,
  output logic [31:0]          params_high,
  output logic [7:0]           checksum,
  output logic                 oversize
);
  import mfpp_pkg::*;

  localparam int SlotW = $clog2(MAX_PARAMS + 1);
  localparam int IdxW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SECOND, PH_SOURCE, PH_COMMAND, PH_OPER,
    PH_LENGTH, PH_PARAM, PH_CHECK, PH_FOOTER
  } phase_t;

  logic [7:0] start_marker, second_marker, footer_marker;

  phase_t     phase, phase_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic [SlotW-1:0] param_slot, param_slot_next;
  logic [7:0] src_hold, src_hold_next;
  logic [7:0] cmd_hold, cmd_hold_next;
  logic [7:0] oper_hold, oper_hold_next;
  logic [7:0] len_hold, len_hold_next;
  logic [7:0] checksum_hold, checksum_hold_next;
  logic [7:0] param_store [MAX_PARAMS];
  logic [7:0] param_store_next [MAX_PARAMS];

  frame_t result;
  logic   emit;
  frame_t out_q, skid_q;
  logic   out_valid, skid_valid;
  logic   rx_acc, out_free;
  logic   clear;
  phase_t phase_eff;
  logic [ParamBits-1:0] params_flat;

  assign cfg_ready = 1'b1;
  assign rx_stall  = skid_valid;
  assign rx_acc    = rx_valid && !skid_valid;
  assign out_free  = !out_valid || !frame_stall;

  // special marker handling ahead of the per phase update
  always_comb begin
    clear     = 1'b0;
    phase_eff = phase;
    if (rx_byte == start_marker) begin
      clear     = 1'b1;
      phase_eff = PH_SECOND;
    end
    if (phase_eff != PH_SECOND && rx_byte == second_marker) begin
      clear     = 1'b1;
      phase_eff = PH_IDLE;
    end
    if (phase_eff != PH_FOOTER && rx_byte == footer_marker) begin
      clear     = 1'b1;
      phase_eff = PH_IDLE;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PARAMS; i++) begin
      params_flat[8*i +: 8] = param_store[i];
    end
  end

  always_comb begin
    phase_next           = phase_eff;
    bytes_remaining_next = clear ? 8'd0 : bytes_remaining;
    param_slot_next      = clear ? '0 : param_slot;
    src_hold_next        = clear ? 8'd0 : src_hold;
    cmd_hold_next        = clear ? 8'd0 : cmd_hold;
    oper_hold_next       = clear ? 8'd0 : oper_hold;
    len_hold_next        = clear ? 8'd0 : len_hold;
    checksum_hold_next   = clear ? 8'd0 : checksum_hold;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      param_store_next[i] = clear ? 8'd0 : param_store[i];
    end
    emit = 1'b0;

    result.source_id   = src_hold;
    result.command     = cmd_hold;
    result.operation   = oper_hold;
    result.data_length = len_hold;
    result.params_low  = '0;
    result.params_high = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < MAX_PARAMS) result.params_low[8*i +: 8] = params_flat[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      if (i + 8 < MAX_PARAMS) result.params_high[8*i +: 8] = params_flat[8*(i+8) +: 8];
    end
    result.checksum = checksum_hold;
    result.oversize = (len_hold > 8'(MAX_PARAMS));

    unique case (phase_eff)
      PH_IDLE: begin
      end
      PH_SECOND: begin
        if (rx_byte == second_marker) phase_next = PH_SOURCE;
      end
      PH_SOURCE: begin
        src_hold_next = rx_byte;
        phase_next    = PH_COMMAND;
      end
      PH_COMMAND: begin
        cmd_hold_next = rx_byte;
        phase_next    = PH_OPER;
      end
      PH_OPER: begin
        oper_hold_next = rx_byte;
        phase_next     = PH_LENGTH;
      end
      PH_LENGTH: begin
        len_hold_next        = rx_byte;
        bytes_remaining_next = rx_byte;
        param_slot_next      = '0;
        phase_next           = (rx_byte == 8'd0) ? PH_CHECK : PH_PARAM;
      end
      PH_PARAM: begin
        // bytes past the buffer are counted but dropped
        if (param_slot_next < SlotW'(MAX_PARAMS)) begin
          param_store_next[param_slot_next[IdxW-1:0]] = rx_byte;
          param_slot_next = param_slot_next + SlotW'(1);
        end
        bytes_remaining_next = bytes_remaining_next - 8'd1;
        if (bytes_remaining_next == 8'd0) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        checksum_hold_next = rx_byte;
        phase_next         = PH_FOOTER;
      end
      PH_FOOTER: begin
        if (rx_byte == footer_marker) begin
          emit                 = 1'b1;
          phase_next           = PH_IDLE;
          bytes_remaining_next = 8'd0;
          param_slot_next      = '0;
          src_hold_next        = 8'd0;
          cmd_hold_next        = 8'd0;
          oper_hold_next       = 8'd0;
          len_hold_next        = 8'd0;
          checksum_hold_next   = 8'd0;
          for (int i = 0; i < MAX_PARAMS; i++) begin
            param_store_next[i] = 8'd0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker    <= START_RESET;
      second_marker   <= SECOND_RESET;
      footer_marker   <= FOOTER_RESET;
      phase           <= PH_IDLE;
      bytes_remaining <= 8'd0;
      param_slot      <= '0;
      src_hold        <= 8'd0;
      cmd_hold        <= 8'd0;
      oper_hold       <= 8'd0;
      len_hold        <= 8'd0;
      checksum_hold   <= 8'd0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        param_store[i] <= 8'd0;
      end
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START:  start_marker  <= cfg_data;
          CFG_SECOND: second_marker <= cfg_data;
          CFG_FOOTER: footer_marker <= cfg_data;
          default: begin
          end
        endcase
      end

      if (rx_acc) begin
        phase           <= phase_next;
        bytes_remaining <= bytes_remaining_next;
        param_slot      <= param_slot_next;
        src_hold        <= src_hold_next;
        cmd_hold        <= cmd_hold_next;
        oper_hold       <= oper_hold_next;
        len_hold        <= len_hold_next;
        checksum_hold   <= checksum_hold_next;
        for (int i = 0; i < MAX_PARAMS; i++) begin
          param_store[i] <= param_store_next[i];
        end
      end

      // skid word drains first, so frames keep their order
      if (skid_valid && out_free) begin
        out_q      <= skid_q;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (rx_acc && emit && out_free) begin
        out_q     <= result;
        out_valid <= 1'b1;
      end else if (rx_acc && emit) begin
        skid_q     <= result;
        skid_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign frame_valid = out_valid;
  assign source_id   = out_q.source_id;
  assign command     = out_q.command;
  assign operation   = out_q.operation;
  assign data_length = out_q.data_length;
  assign params_low  = out_q.params_low;
  assign params_high = out_q.params_high;
  assign checksum    = out_q.checksum;
  assign oversize    = out_q.oversize;

endmodule
